/* hw/rtl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, stage counts, payload types and helpers of the look-at core.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Operand and result widths
  localparam int IN_W   = 32;   // Q16.16 input and output word
  localparam int NIN_W  = 50;   // signed vector entering a normalizer
  localparam int NV_W   = 18;   // normalized component, signed, |v| <= 2^16
  localparam int FR_W   = 64;   // alignment frame
  localparam int M_W    = 30;   // aligned magnitude, leading one at bit 29
  localparam int M_LSB  = FR_W - M_W;
  localparam int SQR_W  = 2 * M_W;
  localparam int SQ_W   = 62;   // radicand and root register width
  localparam int RT_W   = 31;   // integer square root
  localparam int Q_W    = 17;   // quotient magnitude
  localparam int REM_W  = M_W + 17; // dividend and remainder
  localparam int PR_W   = 50;   // 32 x 18 product
  localparam int SUM_W  = 52;   // sum of three products

  // Normalizer stage layout
  localparam int ALIGN_ST  = 3;
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = Q_W;
  localparam int SQR_ST    = ALIGN_ST;
  localparam int SUM_ST    = ALIGN_ST + 1;
  localparam int SQ_FIRST  = ALIGN_ST + 2;
  localparam int DVD_ST    = SQ_FIRST + SQ_STEPS;
  localparam int DIV_FIRST = DVD_ST + 1;
  localparam int NORM_LAT  = DIV_FIRST + DIV_STEPS + 1;
  localparam int CROSS_LAT = 2;
  localparam int XL_LAT    = 3;

  localparam logic [1:0] LAST_COL = 2'd3;

  typedef logic [2:0][NIN_W-1:0] nvec_t;
  typedef logic [2:0][NV_W-1:0]  uvec_t;
  typedef logic [2:0][IN_W-1:0]  wvec_t;

  // One normalizer stage register
  typedef struct packed {
    logic                      vld;
    logic                      zero;
    logic [2:0]                neg;
    logic [2:0][FR_W-1:0]      fr;
    logic [2:0][SQR_W-1:0]     sq;
    logic [SQ_W-1:0]           rad;
    logic [SQ_W-1:0]           root;
    logic [2:0][REM_W-1:0]     rem;
    logic [2:0][Q_W-1:0]       quo;
    uvec_t                     nv;
  } nrm_t;

  // Side words that ride beside the arithmetic units
  typedef struct packed {
    wvec_t eye;
    wvec_t up;
  } sa_t;

  typedef struct packed {
    wvec_t eye;
    uvec_t z;
    logic  deg;
  } sc_t;

  typedef struct packed {
    wvec_t eye;
    uvec_t z;
    uvec_t x;
    logic  deg;
  } se_t;

  typedef struct packed {
    uvec_t x;
    uvec_t y;
    uvec_t z;
    logic  deg;
  } sf_t;

  // Shift all three words left by sh when the top sh bits of all are clear
  function automatic logic [2:0][FR_W-1:0] lstep(input logic [2:0][FR_W-1:0] f,
                                                 input int sh);
    logic [FR_W-1:0]      ow;
    logic [2:0][FR_W-1:0] r;
    ow = f[0] | f[1] | f[2];
    r  = f;
    if ((ow >> (FR_W - sh)) == '0) begin
      for (int i = 0; i < 3; i++) r[i] = f[i] << sh;
    end
    return r;
  endfunction

  // Sign-extend a normalized component to a full word
  function automatic logic [IN_W-1:0] sext_nv(input logic [NV_W-1:0] v);
    return {{(IN_W - NV_W){v[NV_W-1]}}, v};
  endfunction

endpackage

/* hw/rtl/lav_if.sv */
// ----------------------------------------------------------------------------
// lav_in_if / lav_out_if
// Valid/ready channels of the look-at core: input vectors and matrix columns.
// ----------------------------------------------------------------------------
interface lav_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] eye_x;
  logic [31:0] eye_y;
  logic [31:0] eye_z;
  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [31:0] target_z;
  logic [31:0] up_x;
  logic [31:0] up_y;
  logic [31:0] up_z;

  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                up_x, up_y, up_z, output ready);
endinterface

interface lav_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  column_index;
  logic [31:0] row0_value;
  logic [31:0] row1_value;
  logic [31:0] row2_value;
  logic        last_column;
  logic        degenerate;

  modport source (output valid, column_index, row0_value, row1_value, row2_value,
                  last_column, degenerate, input ready);
  modport sink (input valid, column_index, row0_value, row1_value, row2_value,
                last_column, degenerate, output ready);
endinterface

/* hw/rtl/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: align, square, sum, one root bit per stage,
// one quotient bit per stage for all three components, restore sign.
// ----------------------------------------------------------------------------
module lav_norm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  lav_pkg::nvec_t vec_i,
  output logic          vld_o,
  output logic          zero_o,
  output lav_pkg::uvec_t nv_o
);
  import lav_pkg::*;

  nrm_t p_q [NORM_LAT];
  nrm_t p_d [NORM_LAT];
  nrm_t first;

  // Build the entry word: magnitudes in the frame, signs, zero flag
  always_comb begin
    logic [NIN_W-1:0] mag;
    first      = '0;
    first.vld  = vld_i;
    first.zero = (vec_i == '0);
    for (int i = 0; i < 3; i++) begin
      first.neg[i] = vec_i[i][NIN_W-1];
      mag          = vec_i[i][NIN_W-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
      first.fr[i]  = FR_W'(mag);
    end
  end

  // Stage logic
  always_comb begin
    nrm_t               cur;
    logic [SQ_W:0]      tsq;
    logic [SQ_W-1:0]    bitv;
    logic [REM_W-1:0]   tdv;
    int                 sh;
    int                 b;
    for (int j = 0; j < NORM_LAT; j++) begin
      tsq  = '0;
      bitv = '0;
      tdv  = '0;
      sh   = 0;
      b    = 0;
      cur = (j == 0) ? first : p_q[j-1];
      if (j < ALIGN_ST) begin
        // align the largest magnitude to the frame top, two steps a stage
        sh     = 1 << (2 * (ALIGN_ST - 1 - j) + 1);
        cur.fr = lstep(lstep(cur.fr, sh), sh >> 1);
      end else if (j == SQR_ST) begin
        for (int i = 0; i < 3; i++) begin
          cur.sq[i] = cur.fr[i][FR_W-1:M_LSB] * cur.fr[i][FR_W-1:M_LSB];
        end
      end else if (j == SUM_ST) begin
        cur.rad  = SQ_W'(cur.sq[0]) + SQ_W'(cur.sq[1]) + SQ_W'(cur.sq[2]);
        cur.root = '0;
      end else if (j < DVD_ST) begin
        // one root bit
        bitv = SQ_W'(1) << (2 * (SQ_STEPS - 1 - (j - SQ_FIRST)));
        tsq  = {1'b0, cur.root} + {1'b0, bitv};
        if ({1'b0, cur.rad} >= tsq) begin
          cur.rad  = cur.rad - tsq[SQ_W-1:0];
          cur.root = (cur.root >> 1) + bitv;
        end else begin
          cur.root = cur.root >> 1;
        end
      end else if (j == DVD_ST) begin
        // dividend m * 2^16 + floor(L / 2)
        for (int i = 0; i < 3; i++) begin
          cur.rem[i] = {cur.fr[i][FR_W-1:M_LSB], 17'd0} >> 1;
          cur.rem[i] = cur.rem[i] + REM_W'(cur.root[RT_W-1:1]);
          cur.quo[i] = '0;
        end
      end else if (j < NORM_LAT - 1) begin
        // one quotient bit per component
        b = DIV_STEPS - 1 - (j - DIV_FIRST);
        for (int i = 0; i < 3; i++) begin
          tdv = REM_W'(cur.root[RT_W-1:0]) << b;
          if (cur.rem[i] >= tdv) begin
            cur.rem[i]    = cur.rem[i] - tdv;
            cur.quo[i][b] = 1'b1;
          end
        end
      end else begin
        // put the sign back, force zeros for a null vector
        for (int i = 0; i < 3; i++) begin
          if (cur.zero) begin
            cur.nv[i] = '0;
          end else if (cur.neg[i]) begin
            cur.nv[i] = ~{1'b0, cur.quo[i]} + 1'b1;
          end else begin
            cur.nv[i] = {1'b0, cur.quo[i]};
          end
        end
      end
      p_d[j] = cur;
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NORM_LAT; j++) p_q[j] <= '0;
    end else if (en_i) begin
      for (int j = 0; j < NORM_LAT; j++) p_q[j] <= p_d[j];
    end
  end

  assign vld_o  = p_q[NORM_LAT-1].vld;
  assign zero_o = p_q[NORM_LAT-1].zero;
  assign nv_o   = p_q[NORM_LAT-1].nv;

endmodule

/* hw/rtl/lav_cross.sv */
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product: six products, then three differences.
// ----------------------------------------------------------------------------
module lav_cross (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  lav_pkg::wvec_t a_i,
  input  lav_pkg::uvec_t b_i,
  output logic           vld_o,
  output lav_pkg::nvec_t r_o
);
  import lav_pkg::*;

  logic [CROSS_LAT-1:0]   vld_q;
  logic signed [PR_W-1:0] pr_q [6];
  logic signed [PR_W-1:0] pr_d [6];
  nvec_t                  r_q;

  // Form the six products
  always_comb begin
    pr_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    pr_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    pr_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    pr_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    pr_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    pr_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CROSS_LAT-2:0], vld_i};
    end
  end

  // Hold products, then take differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) pr_q[i] <= pr_d[i];
      r_q[0] <= pr_q[0] - pr_q[1];
      r_q[1] <= pr_q[2] - pr_q[3];
      r_q[2] <= pr_q[4] - pr_q[5];
    end
  end

  assign vld_o = vld_q[CROSS_LAT-1];
  assign r_o   = r_q;

endmodule

/* hw/rtl/lav_xlate.sv */
// ----------------------------------------------------------------------------
// lav_xlate
// Translation column: three dot products with the eye, negated, rounded to
// Q16.16 and saturated.
// ----------------------------------------------------------------------------
module lav_xlate (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  lav_pkg::uvec_t x_i,
  input  lav_pkg::uvec_t y_i,
  input  lav_pkg::uvec_t z_i,
  input  lav_pkg::wvec_t eye_i,
  output logic           vld_o,
  output lav_pkg::wvec_t t_o
);
  import lav_pkg::*;

  logic [XL_LAT-1:0]       vld_q;
  logic signed [PR_W-1:0]  pr_q [3][3];
  logic signed [SUM_W-1:0] sum_q [3];
  wvec_t                   t_q;
  uvec_t                   ax [3];

  assign ax[0] = x_i;
  assign ax[1] = y_i;
  assign ax[2] = z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[XL_LAT-2:0], vld_i};
    end
  end

  // Products, sums, then round and saturate
  always_ff @(posedge clk_i) begin
    logic signed [SUM_W:0] acc;
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          pr_q[r][k] <= $signed(ax[r][k]) * $signed(eye_i[k]);
        end
        sum_q[r] <= {{2{pr_q[r][0][PR_W-1]}}, pr_q[r][0]}
                  + {{2{pr_q[r][1][PR_W-1]}}, pr_q[r][1]}
                  + {{2{pr_q[r][2][PR_W-1]}}, pr_q[r][2]};
        acc = -$signed({sum_q[r][SUM_W-1], sum_q[r]}) + (SUM_W+1)'(32768);
        if (!acc[SUM_W] && (|acc[SUM_W-1:47])) begin
          t_q[r] <= 32'h7fff_ffff;
        end else if (acc[SUM_W] && !(&acc[SUM_W-1:47])) begin
          t_q[r] <= 32'h8000_0000;
        end else begin
          t_q[r] <= acc[47:16];
        end
      end
    end
  end

  assign vld_o = vld_q[XL_LAT-1];
  assign t_o   = t_q;

endmodule

/* hw/rtl/look_at_view_matrix_core.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Right-handed look-at view matrix in Q16.16, emitted as four column words.
// ----------------------------------------------------------------------------
// Each accepted input word (eye, target, up) produces four output words,
// columns 0..3 in order, the last flagged by last_column. Columns 0..2 hold
// (x_i, y_i, z_i) of the normalized axes; column 3 holds -(x.eye, y.eye,
// z.eye), rounded and saturated. From acceptance an item passes an input
// register, three normalizers of 55 stages each (one square-root bit per root
// stage and one quotient bit per divide stage), two 2-stage cross products,
// a 3-stage translation unit and the output register. The four columns share
// one output channel, so the core takes a new item only when the output register
// is empty or its last column is being taken; the whole pipeline holds while the output register waits.
module look_at_view_matrix_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lav_in_if.sink    in_i,
  lav_out_if.source out_o
);
  import lav_pkg::*;

  logic              adv;
  logic              s0_vld_q;
  wvec_t             s0_eye_q, s0_up_q;
  nvec_t             s0_d_q;

  logic              nz_vld, nz_zero, c1_vld, nx_vld, nx_zero, c2_vld, ny_vld, ny_zero;
  logic              xl_vld;
  uvec_t             nz_v, nx_v, ny_v;
  nvec_t             c1_r, c2_r;
  wvec_t             zw, xl_t;

  sa_t               sa_q [NORM_LAT];
  sc_t               sb_q [CROSS_LAT];
  sc_t               sc_q [NORM_LAT];
  se_t               sd_q [CROSS_LAT];
  se_t               se_q [NORM_LAT];
  sf_t               sf_q [XL_LAT];
  sc_t               sb_in;
  se_t               sd_in;
  sf_t               sf_in;

  logic              ser_vld_q;
  logic [1:0]        col_q;
  uvec_t             ox_q, oy_q, oz_q;
  wvec_t             ot_q;
  logic              odeg_q;

  // Move everything when the output register can take the next word set
  assign adv        = !ser_vld_q || (out_o.ready && col_q == LAST_COL);
  assign in_i.ready = adv;

  // Input register: eye, up and eye - target
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [IN_W:0] d;
    if (adv) begin
      s0_eye_q <= {in_i.eye_z, in_i.eye_y, in_i.eye_x};
      s0_up_q  <= {in_i.up_z, in_i.up_y, in_i.up_x};
      d = {in_i.eye_x[IN_W-1], in_i.eye_x} - {in_i.target_x[IN_W-1], in_i.target_x};
      s0_d_q[0] <= {{(NIN_W - IN_W - 1){d[IN_W]}}, d};
      d = {in_i.eye_y[IN_W-1], in_i.eye_y} - {in_i.target_y[IN_W-1], in_i.target_y};
      s0_d_q[1] <= {{(NIN_W - IN_W - 1){d[IN_W]}}, d};
      d = {in_i.eye_z[IN_W-1], in_i.eye_z} - {in_i.target_z[IN_W-1], in_i.target_z};
      s0_d_q[2] <= {{(NIN_W - IN_W - 1){d[IN_W]}}, d};
    end
  end

  // z axis
  lav_norm u_norm_z (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(s0_vld_q), .vec_i(s0_d_q),
    .vld_o(nz_vld), .zero_o(nz_zero), .nv_o(nz_v)
  );

  // up cross z
  lav_cross u_cross_x (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(nz_vld), .a_i(sa_q[NORM_LAT-1].up), .b_i(nz_v),
    .vld_o(c1_vld), .r_o(c1_r)
  );

  // x axis
  lav_norm u_norm_x (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(c1_vld), .vec_i(c1_r),
    .vld_o(nx_vld), .zero_o(nx_zero), .nv_o(nx_v)
  );

  // z cross x
  always_comb begin
    for (int i = 0; i < 3; i++) zw[i] = sext_nv(sc_q[NORM_LAT-1].z[i]);
  end

  lav_cross u_cross_y (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(nx_vld), .a_i(zw), .b_i(nx_v),
    .vld_o(c2_vld), .r_o(c2_r)
  );

  // y axis
  lav_norm u_norm_y (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(c2_vld), .vec_i(c2_r),
    .vld_o(ny_vld), .zero_o(ny_zero), .nv_o(ny_v)
  );

  // translation column
  lav_xlate u_xlate (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(ny_vld),
    .x_i(se_q[NORM_LAT-1].x), .y_i(ny_v), .z_i(se_q[NORM_LAT-1].z),
    .eye_i(se_q[NORM_LAT-1].eye), .vld_o(xl_vld), .t_o(xl_t)
  );

  // Side words entering each delay line
  always_comb begin
    sb_in.eye = sa_q[NORM_LAT-1].eye;
    sb_in.z   = nz_v;
    sb_in.deg = nz_zero;
    sd_in.eye = sc_q[NORM_LAT-1].eye;
    sd_in.z   = sc_q[NORM_LAT-1].z;
    sd_in.x   = nx_v;
    sd_in.deg = sc_q[NORM_LAT-1].deg | nx_zero;
    sf_in.x   = se_q[NORM_LAT-1].x;
    sf_in.y   = ny_v;
    sf_in.z   = se_q[NORM_LAT-1].z;
    sf_in.deg = se_q[NORM_LAT-1].deg | ny_zero;
  end

  // Delay lines matched to each unit's depth
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_q[0] <= '{eye: s0_eye_q, up: s0_up_q};
      sc_q[0] <= sb_q[CROSS_LAT-1];
      se_q[0] <= sd_q[CROSS_LAT-1];
      for (int j = 1; j < NORM_LAT; j++) begin
        sa_q[j] <= sa_q[j-1];
        sc_q[j] <= sc_q[j-1];
        se_q[j] <= se_q[j-1];
      end
      sb_q[0] <= sb_in;
      sd_q[0] <= sd_in;
      for (int j = 1; j < CROSS_LAT; j++) begin
        sb_q[j] <= sb_q[j-1];
        sd_q[j] <= sd_q[j-1];
      end
      sf_q[0] <= sf_in;
      for (int j = 1; j < XL_LAT; j++) sf_q[j] <= sf_q[j-1];
    end
  end

  // Output register: load a finished item, then step through its columns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      col_q     <= '0;
    end else if (adv) begin
      ser_vld_q <= xl_vld;
      col_q     <= '0;
    end else if (out_o.ready) begin
      col_q <= col_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q   <= sf_q[XL_LAT-1].x;
      oy_q   <= sf_q[XL_LAT-1].y;
      oz_q   <= sf_q[XL_LAT-1].z;
      odeg_q <= sf_q[XL_LAT-1].deg;
      ot_q   <= xl_t;
    end
  end

  // Column select
  always_comb begin
    out_o.valid        = ser_vld_q;
    out_o.column_index = col_q;
    out_o.last_column  = (col_q == LAST_COL);
    out_o.degenerate   = odeg_q;
    if (col_q == LAST_COL) begin
      out_o.row0_value = ot_q[0];
      out_o.row1_value = ot_q[1];
      out_o.row2_value = ot_q[2];
    end else begin
      out_o.row0_value = sext_nv(ox_q[col_q]);
      out_o.row1_value = sext_nv(oy_q[col_q]);
      out_o.row2_value = sext_nv(oz_q[col_q]);
    end
  end

endmodule

/* dv/look_at_view_matrix_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_core_tb
// Drives eye/target/up words into the look-at core and checks every column
// word against a fixed-point predictor of the view matrix, under random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core_tb;
  import lav_pkg::*;

  typedef struct {
    logic [1:0]  col;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic        last;
    logic        deg;
  } column_t;

  // Hold expected columns and compare arriving words in order
  class matrix_scoreboard;
    column_t pending_cols[$];
    int      mismatches;

    function void note_input(column_t cols[4]);
      for (int k = 0; k < 4; k++) pending_cols.push_back(cols[k]);
    endfunction

    function void check_column(column_t got);
      column_t want;
      if (pending_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column word col=%0d", got.col);
        return;
      end
      want = pending_cols.pop_front();
      if (got.col !== want.col || got.r0 !== want.r0 || got.r1 !== want.r1 ||
          got.r2 !== want.r2 || got.last !== want.last || got.deg !== want.deg) begin
        mismatches++;
        if (mismatches <= 10)
          $display("column mismatch: exp col=%0d %h %h %h last=%b deg=%b got col=%0d %h %h %h last=%b deg=%b",
                   want.col, want.r0, want.r1, want.r2, want.last, want.deg,
                   got.col, got.r0, got.r1, got.r2, got.last, got.deg);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  lav_in_if  in_ch();
  lav_out_if out_ch();

  look_at_view_matrix_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  matrix_scoreboard sb;
  bit   send_done;
  bit   hold_off;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scale to unit length in Q16.16; return 1 on a zero vector
  function automatic bit unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, acc, len, q;
    mx = 0;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) acc += m[i] * m[i];
    len = root_floor(acc);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 16) + (len >> 1)) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  // Negated dot product, rounded to Q16.16 and saturated
  function automatic logic [31:0] shift_term(input longint ax[3], input longint e[3]);
    longint acc;
    acc = -(ax[0] * e[0] + ax[1] * e[1] + ax[2] * e[2]) + (64'sd1 << 15);
    acc = acc >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic void view_columns(input logic [31:0] w[9], output column_t cols[4]);
    longint e[3], d[3], u[3], xa[3], ya[3], za[3], t[3];
    bit deg;
    for (int i = 0; i < 3; i++) begin
      e[i] = longint'(signed'(w[i]));
      d[i] = e[i] - longint'(signed'(w[3+i]));
      u[i] = longint'(signed'(w[6+i]));
    end
    deg = unit_vec(d, za);
    cross_prod(u, za, t);
    deg |= unit_vec(t, xa);
    cross_prod(za, xa, t);
    deg |= unit_vec(t, ya);
    for (int k = 0; k < 4; k++) begin
      cols[k].col  = k[1:0];
      cols[k].last = (k == 3);
      cols[k].deg  = deg;
      if (k < 3) begin
        cols[k].r0 = xa[k][31:0];
        cols[k].r1 = ya[k][31:0];
        cols[k].r2 = za[k][31:0];
      end else begin
        cols[k].r0 = shift_term(xa, e);
        cols[k].r1 = shift_term(ya, e);
        cols[k].r2 = shift_term(za, e);
      end
    end
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0008_0000)
                                     : -$urandom_range(0, 32'h0008_0000);
      3: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Offer one word and wait until accepted
  task automatic send_vectors(input logic [31:0] w[9]);
    column_t cols[4];
    in_ch.valid    <= 1'b1;
    in_ch.eye_x    <= w[0];
    in_ch.eye_y    <= w[1];
    in_ch.eye_z    <= w[2];
    in_ch.target_x <= w[3];
    in_ch.target_y <= w[4];
    in_ch.target_z <= w[5];
    in_ch.up_x     <= w[6];
    in_ch.up_y     <= w[7];
    in_ch.up_z     <= w[8];
    do @(posedge clk_i); while (!in_ch.ready);
    view_columns(w, cols);
    sb.note_input(cols);
  endtask

  task automatic send_gap(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [31:0] w[9];
    int gap;
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.eye_x = '0; in_ch.eye_y = '0; in_ch.eye_z = '0;
    in_ch.target_x = '0; in_ch.target_y = '0; in_ch.target_z = '0;
    in_ch.up_x = '0; in_ch.up_y = '0; in_ch.up_z = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: usual camera, degenerate vectors, extremes
    for (int n = 0; n < 20; n++) begin
      for (int i = 0; i < 9; i++) w[i] = '0;
      case (n)
        0: begin w[2] = 32'h0005_0000; w[7] = 32'h0001_0000; end
        1: ;                                          // zero view direction
        2: begin w[2] = 32'h0001_0000; w[8] = 32'h0001_0000; end  // up along z
        3: begin w[2] = 32'h0001_0000; end            // zero up
        4: begin for (int i = 0; i < 3; i++) w[i] = 32'h7fff_ffff;
                 for (int i = 3; i < 9; i++) w[i] = 32'h8000_0000; end
        5: begin for (int i = 0; i < 3; i++) w[i] = 32'h8000_0000;
                 for (int i = 3; i < 6; i++) w[i] = 32'h7fff_ffff;
                 w[6] = 32'h7fff_ffff; end
        6: begin w[0] = 32'h0000_0001; w[7] = 32'h0000_0001; end
        7: begin for (int i = 0; i < 9; i++) w[i] = 32'hffff_ffff; w[0] = 32'h0; end
        default: for (int i = 0; i < 9; i++) w[i] = rand_field();
      endcase
      send_vectors(w);
      gap = $urandom_range(0, 13);
      if (gap != 0) send_gap(gap);
    end
    // Random: mostly ordinary cameras, some extreme words
    for (int n = 0; n < 160; n++) begin
      for (int i = 0; i < 9; i++)
        w[i] = ($urandom_range(0, 3) == 0) ? rand_field() : $urandom();
      send_vectors(w);
      gap = (n >= 60 && n < 100) ? 0 : $urandom_range(0, 13);
      if (gap != 0) send_gap(gap);
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // Long output hold-off while the stimulus keeps offering input
  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (600) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Receiver: random stalls, check each accepted word
  initial begin
    column_t got;
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got.col  = out_ch.column_index;
      got.r0   = out_ch.row0_value;
      got.r1   = out_ch.row1_value;
      got.r2   = out_ch.row2_value;
      got.last = out_ch.last_column;
      got.deg  = out_ch.degenerate;
      sb.check_column(got);
    end
  end

  // End of run
  initial begin
    wait (send_done);
    while (sb.pending_cols.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
